/* hdl/lss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the LIFO stack with linear search.
// ----------------------------------------------------------------------------
package lss_pkg;

  // Default sizes
  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  // Fixed port field widths
  localparam int OP_W        = 2;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 6;
  localparam int WORD_W      = 32;
  localparam int DEPTH_NOW_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH        = 2'd0,
    OP_POP         = 2'd1,
    OP_FIND_TOP    = 2'd2,
    OP_FIND_BOTTOM = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_REPLY
  } state_t;

  // Cell move: hold, shift toward the bottom (push), shift toward the top
  // (pop and search rotation)
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,
    SH_UP
  } shift_t;

endpackage

/* hdl/lss_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_cell
// One stack slot: holds a word, loads from either neighbor on a shift.
// ----------------------------------------------------------------------------
module lss_cell import lss_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  shift_t               shift,
  input  logic [WORD_BITS-1:0] down_in,
  input  logic [WORD_BITS-1:0] up_in,
  output logic [WORD_BITS-1:0] data
);

  always_ff @(posedge clk) begin
    case (shift)
      SH_DOWN: data <= down_in;
      SH_UP:   data <= up_in;
      default: data <= data;
    endcase
  end

endmodule

/* hdl/lss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer: fill count, search walk over the rotating cell chain,
// comparator at the top cell, and the result register.
// ----------------------------------------------------------------------------
module lss_ctrl import lss_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        op,
  input  logic [VALUE_W-1:0]     value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [POS_W-1:0]       position,
  output logic [WORD_W-1:0]      word,
  output logic [DEPTH_NOW_W-1:0] depth_now,
  input  logic [WORD_BITS-1:0]   tap,
  output shift_t                 shift,
  output logic [WORD_BITS-1:0]   push_word
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  state_t                state, state_next;
  logic [FW-1:0]         fill, fill_next;
  logic [AW-1:0]         k;
  logic                  found;
  logic                  from_bottom;
  logic [WORD_BITS-1:0]  key;
  logic [AW-1:0]         match_pos;
  logic [WORD_BITS-1:0]  match_word;

  logic                  accept;
  logic                  out_free;
  logic                  hit;
  logic                  load_out;
  status_t               res_status;
  logic [AW-1:0]         res_pos;
  logic [WORD_BITS-1:0]  res_word;
  logic                  is_full;
  logic                  is_empty;
  logic                  last_step;

  assign push_word = WORD_BITS'(value);
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign is_full   = (fill == FW'(DEPTH));
  assign is_empty  = (fill == '0);
  assign last_step = (k == AW'(DEPTH - 1));
  assign hit       = (tap == key) && (FW'(k) < fill);

  always_comb begin
    state_next = state;
    fill_next  = fill;
    shift      = SH_HOLD;
    load_out   = 1'b0;
    res_status = ST_OK;
    res_pos    = '0;
    res_word   = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(op))
            OP_PUSH: begin
              load_out = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                shift     = SH_DOWN;
                res_pos   = AW'(fill);
                res_word  = push_word;
                fill_next = FW'(fill + FW'(1));
              end
            end
            OP_POP: begin
              load_out = 1'b1;
              if (is_empty) begin
                res_status = ST_MISS;
              end else begin
                shift     = SH_UP;
                res_pos   = AW'(fill - FW'(1));
                res_word  = tap;
                fill_next = FW'(fill - FW'(1));
              end
            end
            default: state_next = S_SEARCH;
          endcase
        end
      end
      S_SEARCH: begin
        // rotate the whole chain once around so it ends where it started
        shift = SH_UP;
        if (last_step) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          if (found) begin
            res_pos  = match_pos;
            res_word = match_word;
          end else begin
            res_status = ST_MISS;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      k         <= '0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && accept) begin
        k     <= '0;
        found <= 1'b0;
      end else if (state == S_SEARCH) begin
        k <= AW'(k + AW'(1));
        if (hit && (from_bottom || !found)) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Search payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      key         <= push_word;
      from_bottom <= (op_t'(op) == OP_FIND_BOTTOM);
    end
    // top entry arrives first; find from bottom keeps the last hit
    if (state == S_SEARCH && hit && (from_bottom || !found)) begin
      match_pos  <= AW'(fill - FW'(1) - FW'(k));
      match_word <= tap;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      status    <= res_status;
      position  <= POS_W'(res_pos);
      word      <= WORD_W'(res_word);
      depth_now <= DEPTH_NOW_W'(fill_next);
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill count above depth");

  a_search_rotates: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> shift == SH_UP)
    else $error("chain not rotating during search");

  a_search_length: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH && last_step |=> state == S_REPLY)
    else $error("search did not end after a full rotation");

  a_full_push_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && accept && op_t'(op) == OP_PUSH && is_full |=> fill == $past(fill))
    else $error("rejected push changed fill count");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MISS |-> position == '0 && word == '0)
    else $error("miss result carries nonzero position or word");
`endif

endmodule

/* hdl/lifo_stack_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Fixed-depth LIFO stack of words built as a chain of shift cells, with
// find from top and find from bottom through one comparator.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Beat fields
//   --------+----------------------+-----------------------------------
//   in      | in_valid / in_stall  | op, value
//   out     | out_valid / out_stall| status, position, word, depth_now
//
// Push and pop: the result beat is offered in the cycle after the input beat.
// Find: the chain rotates one full turn past the comparator at the top cell,
//   which also restores its order.
// A new input beat is taken only while no search runs and the result
//   register is free or being drained in the same cycle.
// Reset clears the fill count and control; cell contents are left as is.
// Stalling out holds the result; search work is never lost.
//
// Cell 0 is the top of the stack; push shifts every cell one place down,
// pop shifts every cell one place up, with cell DEPTH-1 loading cell 0.
// ----------------------------------------------------------------------------
module lifo_stack_with_search import lss_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        op,
  input  logic [VALUE_W-1:0]     value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [POS_W-1:0]       position,
  output logic [WORD_W-1:0]      word,
  output logic [DEPTH_NOW_W-1:0] depth_now
);

  // Cell outputs; each entry feeds its fixed neighbor taps, and cell 0 also feeds the comparator
  logic [WORD_BITS-1:0] cell_data [DEPTH];
  logic [WORD_BITS-1:0] push_word;
  shift_t               shift;

  // Sequencer and result register
  lss_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position),
    .word      (word),
    .depth_now (depth_now),
    .tap       (cell_data[0]),
    .shift     (shift),
    .push_word (push_word)
  );

  // Chain of cells: down feed from the cell above (new word at the top),
  // up feed from the cell below with wraparound for rotation
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int UP = (i + 1) % DEPTH;
    logic [WORD_BITS-1:0] down_in;

    if (i == 0) begin : g_top
      assign down_in = push_word;
    end else begin : g_mid
      assign down_in = cell_data[i-1];
    end

    lss_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk     (clk),
      .shift   (shift),
      .down_in (down_in),
      .up_in   (cell_data[UP]),
      .data    (cell_data[i])
    );
  end

endmodule
